// File: design/salb_pkg.sv
// Shared types and constants for the suffix array and LCP builder.
// Depends on nothing; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package salb_pkg;

    // The text buffer is at most 64 bytes deep.
    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int LEN_W       = 7;

    // A rank holds a byte plus one, so it needs nine bits.
    localparam int RANK_W      = 9;
    localparam int BUCKETS     = 257;
    localparam int BKT_W       = 9;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_INIT    = 4'd1;
    localparam logic [3:0] OP_CLEAR   = 4'd2;
    localparam logic [3:0] OP_COUNT   = 4'd3;
    localparam logic [3:0] OP_PREFIX  = 4'd4;
    localparam logic [3:0] OP_PLACE   = 4'd5;
    localparam logic [3:0] OP_COPY    = 4'd6;
    localparam logic [3:0] OP_RERANK  = 4'd7;
    localparam logic [3:0] OP_RCOPY   = 4'd8;
    localparam logic [3:0] OP_INVERSE = 4'd9;
    localparam logic [3:0] OP_KASAI   = 4'd10;
    localparam logic [3:0] OP_EMIT    = 4'd11;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic [3:0]       op;
        logic             first;
        logic             use_off;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             done;
        logic             all_distinct;
        logic             last_pass;
    } t_status;

endpackage

// File: design/salb_ctrl.sv
// Controller state machine of the suffix array and LCP builder.
// Depends on salb_pkg; sequences the datapath phases by command and status.
`timescale 1ns / 1ps

module salb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_run,
    input  salb_pkg::t_status   i_status,
    output salb_pkg::t_cmd      o_cmd,
    output logic                o_busy
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INIT    = 4'd1;
    localparam logic [3:0] S_CLEAR   = 4'd2;
    localparam logic [3:0] S_COUNT   = 4'd3;
    localparam logic [3:0] S_PREFIX  = 4'd4;
    localparam logic [3:0] S_PLACE   = 4'd5;
    localparam logic [3:0] S_COPY    = 4'd6;
    localparam logic [3:0] S_RERANK  = 4'd7;
    localparam logic [3:0] S_RCOPY   = 4'd8;
    localparam logic [3:0] S_INVERSE = 4'd9;
    localparam logic [3:0] S_KASAI   = 4'd10;
    localparam logic [3:0] S_EMIT    = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_use_off, n_use_off;
    logic       r_first, n_first;

    // Next state: each phase runs until the datapath reports done.
    always_comb begin
        n_state   = r_state;
        n_use_off = r_use_off;
        n_first   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_run) begin
                    n_state = S_INIT;
                    n_first = 1'b1;
                end
            end
            S_INIT: begin
                if (i_status.done) begin
                    n_first = 1'b1;
                    n_use_off = 1'b1;
                    n_state = i_status.last_pass ? S_INVERSE : S_CLEAR;
                end
            end
            S_CLEAR:  if (i_status.done) begin n_state = S_COUNT;  n_first = 1'b1; end
            S_COUNT:  if (i_status.done) begin n_state = S_PREFIX; n_first = 1'b1; end
            S_PREFIX: if (i_status.done) begin n_state = S_PLACE;  n_first = 1'b1; end
            S_PLACE:  if (i_status.done) begin n_state = S_COPY;   n_first = 1'b1; end
            S_COPY: begin
                if (i_status.done) begin
                    n_first = 1'b1;
                    if (r_use_off) begin
                        n_use_off = 1'b0;
                        n_state   = S_CLEAR;
                    end else begin
                        n_state = S_RERANK;
                    end
                end
            end
            S_RERANK: if (i_status.done) begin n_state = S_RCOPY; n_first = 1'b1; end
            S_RCOPY: begin
                if (i_status.done) begin
                    n_first = 1'b1;
                    n_use_off = 1'b1;
                    if (i_status.all_distinct || i_status.last_pass) n_state = S_INVERSE;
                    else n_state = S_CLEAR;
                end
            end
            S_INVERSE: if (i_status.done) begin n_state = S_KASAI; n_first = 1'b1; end
            S_KASAI:   if (i_status.done) begin n_state = S_EMIT;  n_first = 1'b1; end
            S_EMIT:    if (i_status.done) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_use_off <= 1'b1;
            r_first   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_use_off <= n_use_off;
            r_first   <= n_first;
        end
    end

    // State codes double as datapath operation codes.
    assign o_cmd.op      = r_state;
    assign o_cmd.first   = r_first;
    assign o_cmd.use_off = r_use_off;
    assign o_busy        = (r_state != S_IDLE);

endmodule

// File: design/salb_datapath.sv
// Datapath of the suffix array and LCP builder: stores, counters and the sweeps.
// Depends on salb_pkg; driven by commands from salb_ctrl.
`timescale 1ns / 1ps

module salb_datapath #(
    parameter int MAX_LEN = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic [7:0]              i_char_byte,
    input  logic                    i_last_char,
    input  salb_pkg::t_cmd          i_cmd,
    output salb_pkg::t_status       o_status,
    output logic                    o_run,
    output logic                    o_valid,
    output logic [5:0]              o_sorted_position,
    output logic [5:0]              o_suffix_start,
    output logic [5:0]              o_lcp_with_previous,
    output logic                    o_overflowed,
    output logic                    o_last_result
);

    localparam int IW = salb_pkg::IDX_W;
    localparam int LW = salb_pkg::LEN_W;
    localparam int RW = salb_pkg::RANK_W;
    localparam int BW = salb_pkg::BKT_W;
    localparam int D  = salb_pkg::STORE_DEPTH;
    localparam int NB = salb_pkg::BUCKETS;

    // Memories; each is read at one address and written at one address per cycle.
    logic [7:0]    m_text    [D];
    logic [IW-1:0] m_order   [D];
    logic [IW-1:0] m_sorted  [D];
    logic [RW-1:0] m_rank    [D];
    logic [RW-1:0] m_scratch [D];
    logic [IW-1:0] m_inv     [D];
    logic [IW-1:0] m_lcp     [D];
    logic [LW-1:0] m_bkt     [NB];

    logic [LW-1:0] r_len;
    logic          r_ovf;
    logic [LW-1:0] r_k;
    logic [BW-1:0] r_i;
    logic [2:0]    r_ph;
    logic [LW-1:0] r_acc;
    logic [LW-1:0] r_cnt;
    logic [IW-1:0] r_a, r_b;
    logic [RW-1:0] r_ra, r_rb, r_ka, r_kb, r_key, r_sa;
    logic [LW-1:0] r_h;
    logic [IW-1:0] r_j, r_p;
    logic [7:0]    r_ca;
    logic [7:0]    r_cb;
    logic          r_done, r_distinct;

    logic [3:0]    op;
    logic [LW-1:0] off;
    logic [LW-1:0] pq;
    logic [LW-1:0] n_len;

    assign op  = i_cmd.op;
    assign off = i_cmd.use_off ? r_k : '0;

    // Byte loading and run start.
    always_ff @(posedge i_clk) begin
        if (i_load && r_len < LW'(MAX_LEN)) m_text[r_len[IW-1:0]] <= i_char_byte;
    end

    always_comb begin
        n_len = r_len;
        if (i_load && r_len < LW'(MAX_LEN)) n_len = r_len + 1'b1;
    end

    assign o_run = i_load && i_last_char;

    // Sweep engine: each operation walks its store with an index, most also with a sub-phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_done  <= 1'b0;
            o_valid <= 1'b0;
            r_i     <= '0;
            r_ph    <= '0;
        end else begin
            r_done  <= 1'b0;
            o_valid <= 1'b0;
            if (i_load) begin
                r_len <= n_len;
                if (!(r_len < LW'(MAX_LEN))) r_ovf <= 1'b1;
            end
            if (i_cmd.first) begin
                // The placement sweep walks the order from the top down.
                r_i  <= (op == salb_pkg::OP_PLACE) ? BW'(r_len - 1'b1) : '0;
                r_ph <= '0;
                r_acc <= '0;
                r_h  <= '0;
            end else if (!r_done) begin
                case (op)
                    salb_pkg::OP_INIT: begin
                        if (r_ph == 3'd0) begin
                            r_ca <= m_text[r_i[IW-1:0]];
                            r_ph <= 3'd1;
                        end else begin
                            m_order[r_i[IW-1:0]] <= r_i[IW-1:0];
                            m_rank[r_i[IW-1:0]]  <= RW'(r_ca) + 1'b1;
                            r_ph <= 3'd0;
                            r_k  <= LW'(1);
                            if (r_i == BW'(r_len - 1'b1)) r_done <= 1'b1;
                            else r_i <= r_i + 1'b1;
                        end
                    end
                    salb_pkg::OP_CLEAR: begin
                        m_bkt[r_i] <= '0;
                        if (r_i == BW'(NB - 1)) r_done <= 1'b1;
                        else r_i <= r_i + 1'b1;
                    end
                    salb_pkg::OP_COUNT, salb_pkg::OP_PLACE: begin
                        // Phase 0 reads the order, 1 reads the key, 2 reads the
                        // bucket, 3 updates it.
                        case (r_ph)
                            3'd0: begin
                                r_a  <= m_order[r_i[IW-1:0]];
                                r_ph <= 3'd1;
                            end
                            3'd1: begin
                                if (pq < r_len) r_key <= m_rank[pq[IW-1:0]];
                                else r_key <= '0;
                                r_ph <= 3'd2;
                            end
                            3'd2: begin
                                r_acc <= m_bkt[r_key];
                                r_ph  <= 3'd3;
                            end
                            default: begin
                                r_ph <= 3'd0;
                                if (op == salb_pkg::OP_COUNT) begin
                                    m_bkt[r_key] <= r_acc + 1'b1;
                                    if (r_i == BW'(r_len - 1'b1)) r_done <= 1'b1;
                                    else r_i <= r_i + 1'b1;
                                end else begin
                                    m_bkt[r_key] <= r_acc - 1'b1;
                                    m_sorted[r_acc[IW-1:0] - 1'b1] <= r_a;
                                    if (r_i == '0) r_done <= 1'b1;
                                    else r_i <= r_i - 1'b1;
                                end
                            end
                        endcase
                    end
                    salb_pkg::OP_PREFIX: begin
                        // Phase 0 reads a bucket, phase 1 writes the running sum.
                        if (r_ph == 3'd0) begin
                            r_cnt <= m_bkt[r_i];
                            r_ph <= 3'd1;
                        end else begin
                            r_acc <= r_acc + r_cnt;
                            m_bkt[r_i] <= r_acc + r_cnt;
                            r_ph <= 3'd0;
                            if (r_i == BW'(NB - 1)) begin
                                r_done <= 1'b1;
                                r_i <= BW'(r_len - 1'b1);
                            end else r_i <= r_i + 1'b1;
                        end
                    end
                    salb_pkg::OP_COPY: begin
                        if (r_ph == 3'd0) begin
                            r_a  <= m_sorted[r_i[IW-1:0]];
                            r_ph <= 3'd1;
                        end else begin
                            m_order[r_i[IW-1:0]] <= r_a;
                            r_ph <= 3'd0;
                            if (r_i == BW'(r_len - 1'b1)) r_done <= 1'b1;
                            else r_i <= r_i + 1'b1;
                        end
                    end
                    salb_pkg::OP_RERANK: begin
                        // Compare neighbors b and prev on rank and rank at offset k.
                        case (r_ph)
                            3'd0: begin
                                r_b  <= m_order[r_i[IW-1:0]];
                                r_ph <= 3'd1;
                            end
                            3'd1: begin
                                r_rb <= m_rank[r_b];
                                r_ph <= 3'd2;
                            end
                            3'd2: begin
                                if (pq < r_len) r_kb <= m_rank[pq[IW-1:0]];
                                else r_kb <= '0;
                                r_ph <= 3'd3;
                            end
                            3'd3: begin
                                if (r_i == '0) r_sa <= RW'(1);
                                else if (!(r_rb == r_ra && r_kb == r_ka)) r_sa <= r_sa + 1'b1;
                                r_ph <= 3'd4;
                            end
                            default: begin
                                m_scratch[r_b] <= r_sa;
                                r_ra <= r_rb;
                                r_ka <= r_kb;
                                r_ph <= 3'd0;
                                if (r_i == BW'(r_len - 1'b1)) begin
                                    r_done <= 1'b1;
                                    r_distinct <= (r_sa == RW'(r_len));
                                end else r_i <= r_i + 1'b1;
                            end
                        endcase
                    end
                    salb_pkg::OP_RCOPY: begin
                        if (r_ph == 3'd0) begin
                            r_sa <= m_scratch[r_i[IW-1:0]];
                            r_ph <= 3'd1;
                        end else begin
                            m_rank[r_i[IW-1:0]] <= r_sa;
                            r_ph <= 3'd0;
                            if (r_i == BW'(r_len - 1'b1)) begin
                                r_done <= 1'b1;
                                r_k <= r_k << 1;
                            end else r_i <= r_i + 1'b1;
                        end
                    end
                    salb_pkg::OP_INVERSE: begin
                        if (r_ph == 3'd0) begin
                            r_a  <= m_order[r_i[IW-1:0]];
                            r_ph <= 3'd1;
                        end else begin
                            m_inv[r_a] <= r_i[IW-1:0];
                            r_ph <= 3'd0;
                            if (r_i == BW'(r_len - 1'b1)) r_done <= 1'b1;
                            else r_i <= r_i + 1'b1;
                        end
                    end
                    salb_pkg::OP_KASAI: begin
                        // Phase 0 reads p, 1 reads j, then phases 2 to 4 compare one char pair.
                        case (r_ph)
                            3'd0: begin
                                r_p  <= m_inv[r_i[IW-1:0]];
                                r_ph <= 3'd1;
                            end
                            3'd1: begin
                                if (r_p == '0) begin
                                    m_lcp[0] <= '0;
                                    r_h <= '0;
                                    r_ph <= 3'd6;
                                end else begin
                                    r_j  <= m_order[r_p - 1'b1];
                                    r_ph <= 3'd2;
                                end
                            end
                            3'd2: begin
                                if ((LW'(r_i) + r_h) < r_len && (LW'(r_j) + r_h) < r_len) begin
                                    r_ca <= m_text[IW'(LW'(r_i) + r_h)];
                                    r_ph <= 3'd3;
                                end else r_ph <= 3'd5;
                            end
                            3'd3: begin
                                r_cb <= m_text[IW'(LW'(r_j) + r_h)];
                                r_ph <= 3'd4;
                            end
                            3'd4: begin
                                if (r_ca == r_cb) begin
                                    r_h  <= r_h + 1'b1;
                                    r_ph <= 3'd2;
                                end else r_ph <= 3'd5;
                            end
                            3'd5: begin
                                m_lcp[r_p] <= r_h[IW-1:0];
                                if (r_h != '0) r_h <= r_h - 1'b1;
                                r_ph <= 3'd6;
                            end
                            default: begin
                                r_ph <= 3'd0;
                                if (r_i == BW'(r_len - 1'b1)) r_done <= 1'b1;
                                else r_i <= r_i + 1'b1;
                            end
                        endcase
                    end
                    salb_pkg::OP_EMIT: begin
                        if (r_ph == 3'd0) begin
                            o_suffix_start      <= m_order[r_i[IW-1:0]];
                            o_lcp_with_previous <= m_lcp[r_i[IW-1:0]];
                            o_sorted_position   <= r_i[IW-1:0];
                            o_overflowed        <= r_ovf;
                            o_last_result       <= (r_i == BW'(r_len - 1'b1));
                            o_valid             <= 1'b1;
                            if (r_i == BW'(r_len - 1'b1)) begin
                                r_done <= 1'b1;
                                r_len  <= '0;
                                r_ovf  <= 1'b0;
                            end else r_i <= r_i + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Key address: suffix start plus offset for the sorts, b plus k for re-ranking.
    assign pq = (op == salb_pkg::OP_RERANK) ? (LW'(r_b) + r_k) : (LW'(r_a) + off);

    assign o_status.done         = r_done;
    assign o_status.all_distinct = r_distinct;
    assign o_status.last_pass    = (r_k >= r_len);

endmodule

// File: design/suffix_array_lcp_builder_top.sv
// Top level of the suffix array and LCP builder.
// Depends on salb_pkg, salb_ctrl and salb_datapath.
// Usage:
// One byte of text is a transaction on start with busy low, carrying
// i_char_byte and i_last_char. Bytes past MAX_LEN are dropped and flagged.
// The marked final byte starts the build and raises busy until every result
// has been shown.
// Build time is set by the memory sweeps of the datapath: per doubling pass
// two counting sorts (clear, count, prefix, place, copy), a re-rank and a
// rank copy, then the inverse, the Kasai scan and the output; every phase
// ends with a hand-off to the controller. For 64 bytes one pass may
// suffice, and all six passes are needed for one repeated byte.
// Each result is shown for one cycle with o_valid high, in sorted order;
// the last one carries o_last_result. The receiver cannot stall.
// Reset clears the length, the overflow flag and the controller; the bucket
// store is cleared by a sweep over all 257 buckets before every sort.
`timescale 1ns / 1ps

module suffix_array_lcp_builder_top #(
    parameter int MAX_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_char_byte,
    input  logic        i_last_char,
    output logic        o_valid,
    output logic [5:0]  o_sorted_position,
    output logic [5:0]  o_suffix_start,
    output logic [5:0]  o_lcp_with_previous,
    output logic        o_overflowed,
    output logic        o_last_result
);

    salb_pkg::t_cmd    w_cmd;
    salb_pkg::t_status w_status;
    logic              w_run;
    logic              w_load;

    // A byte is taken when the builder is idle.
    assign w_load = start && !busy;

    salb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_run    (w_run),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    salb_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_load              (w_load),
        .i_char_byte         (i_char_byte),
        .i_last_char         (i_last_char),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .o_run               (w_run),
        .o_valid             (o_valid),
        .o_sorted_position   (o_sorted_position),
        .o_suffix_start      (o_suffix_start),
        .o_lcp_with_previous (o_lcp_with_previous),
        .o_overflowed        (o_overflowed),
        .o_last_result       (o_last_result)
    );

endmodule

// File: design/salb_checker.sv
// Port-level checks for the suffix array and LCP builder.
// Depends on suffix_array_lcp_builder_top, to which it is bound.
`timescale 1ns / 1ps

module salb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_last_char,
    input logic       o_valid,
    input logic [5:0] o_sorted_position,
    input logic [5:0] o_lcp_with_previous,
    input logic       o_last_result
);

    // Results appear only while a build runs.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result outside a build");

    // The first position has no previous suffix.
    a_lcp0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sorted_position == 6'd0) |-> o_lcp_with_previous == 6'd0)
        else $error("nonzero lcp at position zero");

    // A final byte transaction starts a build.
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_char) |=> busy) else $error("build did not start");

    // After the last result the builder goes idle.
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_result) |=> !busy) else $error("busy after last result");

endmodule

bind suffix_array_lcp_builder_top salb_checker u_chk (.*);

// File: tb/suffix_array_lcp_builder_checker.sv
// Checker for the suffix array and LCP builder: predicts sorted suffixes and LCPs.
// Depends on the top level's port set; watches the input and result channels.
`timescale 1ns / 1ps

module suffix_array_lcp_builder_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [7:0] i_char_byte,
    input  logic       i_last_char,
    input  logic       i_valid,
    input  logic [5:0] i_sorted_position,
    input  logic [5:0] i_suffix_start,
    input  logic [5:0] i_lcp_with_previous,
    input  logic       i_overflowed,
    input  logic       i_last_result,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int MAX_LEN = 64;

    typedef struct packed {
        logic [5:0] pos;
        logic [5:0] start;
        logic [5:0] lcp;
        logic       ovf;
        logic       last;
    } t_suffix_entry;

    t_suffix_entry expected_suffixes[$];
    logic [7:0]    text_buf[MAX_LEN];
    int            text_len;
    logic          text_ovf;

    assign o_pending = expected_suffixes.size();

    // Stable counting sort of the order array by rank at offset off.
    function automatic void rank_sort(ref int order[MAX_LEN], ref int rnk[MAX_LEN],
                                      input int off, input int n);
        int cnt[257];
        int sorted[MAX_LEN];
        int key;
        foreach (cnt[b]) cnt[b] = 0;
        for (int i = 0; i < n; i++) begin
            key = (order[i] + off < n) ? rnk[order[i] + off] : 0;
            cnt[key]++;
        end
        for (int b = 1; b < 257; b++) cnt[b] += cnt[b - 1];
        for (int i = n - 1; i >= 0; i--) begin
            key = (order[i] + off < n) ? rnk[order[i] + off] : 0;
            cnt[key]--;
            sorted[cnt[key]] = order[i];
        end
        for (int i = 0; i < n; i++) order[i] = sorted[i];
    endfunction

    // Prefix doubling, then Kasai, queuing one expectation per sorted position.
    task automatic predict_suffixes();
        int order[MAX_LEN];
        int rnk[MAX_LEN];
        int nrk[MAX_LEN];
        int inv[MAX_LEN];
        int lcp[MAX_LEN];
        int n, a, b, h, j, ka, kb;
        t_suffix_entry e;
        n = text_len;
        for (int i = 0; i < n; i++) begin
            order[i] = i;
            rnk[i] = text_buf[i] + 1;
        end
        for (int k = 1; k < n; k <<= 1) begin
            rank_sort(order, rnk, k, n);
            rank_sort(order, rnk, 0, n);
            nrk[order[0]] = 1;
            for (int i = 1; i < n; i++) begin
                a = order[i - 1];
                b = order[i];
                ka = (a + k < n) ? rnk[a + k] : 0;
                kb = (b + k < n) ? rnk[b + k] : 0;
                nrk[b] = nrk[a] + ((rnk[a] == rnk[b] && ka == kb) ? 0 : 1);
            end
            for (int i = 0; i < n; i++) rnk[i] = nrk[i];
            if (rnk[order[n - 1]] == n) break;
        end
        for (int i = 0; i < n; i++) inv[order[i]] = i;
        h = 0;
        for (int i = 0; i < n; i++) begin
            if (inv[i] == 0) begin
                lcp[0] = 0;
                h = 0;
            end else begin
                j = order[inv[i] - 1];
                while (i + h < n && j + h < n && text_buf[i + h] == text_buf[j + h]) h++;
                lcp[inv[i]] = h;
                if (h > 0) h--;
            end
        end
        for (int i = 0; i < n; i++) begin
            e.pos   = i[5:0];
            e.start = order[i][5:0];
            e.lcp   = lcp[i][5:0];
            e.ovf   = text_ovf;
            e.last  = (i == n - 1);
            expected_suffixes.push_back(e);
        end
        text_len = 0;
        text_ovf = 1'b0;
    endtask

    // Track accepted bytes and compare every shown result.
    always @(posedge i_clk) begin
        t_suffix_entry e;
        if (!i_rst_n) begin
            text_len = 0;
            text_ovf = 1'b0;
            o_fail_count <= 0;
        end else begin
            if (i_valid) begin
                if (expected_suffixes.size() == 0) begin
                    $error("result with no expectation: pos %0d", i_sorted_position);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_suffixes.pop_front();
                    if ({i_sorted_position, i_suffix_start, i_lcp_with_previous,
                         i_overflowed, i_last_result} != e) begin
                        o_fail_count <= o_fail_count + 1;
                        if (i_sorted_position != e.pos)
                            $error("sorted_position: expected %0d got %0d",
                                   e.pos, i_sorted_position);
                        if (i_suffix_start != e.start)
                            $error("suffix_start: expected %0d got %0d",
                                   e.start, i_suffix_start);
                        if (i_lcp_with_previous != e.lcp)
                            $error("lcp_with_previous: expected %0d got %0d",
                                   e.lcp, i_lcp_with_previous);
                        if (i_overflowed != e.ovf)
                            $error("overflowed: expected %0d got %0d",
                                   e.ovf, i_overflowed);
                        if (i_last_result != e.last)
                            $error("last_result: expected %0d got %0d",
                                   e.last, i_last_result);
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (text_len < MAX_LEN) begin
                    text_buf[text_len] = i_char_byte;
                    text_len = text_len + 1;
                end else begin
                    text_ovf = 1'b1;
                end
                if (i_last_char) predict_suffixes();
            end
        end
    end

endmodule

// File: tb/suffix_array_lcp_builder_top_tb.sv
// Testbench top for the suffix array and LCP builder: drives texts byte by byte.
// Depends on suffix_array_lcp_builder_top and suffix_array_lcp_builder_checker.
`timescale 1ns / 1ps

module suffix_array_lcp_builder_top_tb;

    localparam int WATCHDOG_LIMIT = 100000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [7:0] i_char_byte = 8'd0;
    logic       i_last_char = 1'b0;
    logic       o_valid;
    logic [5:0] o_sorted_position;
    logic [5:0] o_suffix_start;
    logic [5:0] o_lcp_with_previous;
    logic       o_overflowed;
    logic       o_last_result;
    int         fail_count;
    int         pending;
    int         idle_pct = 0;
    int         quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    suffix_array_lcp_builder_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_char_byte(i_char_byte), .i_last_char(i_last_char), .o_valid(o_valid),
        .o_sorted_position(o_sorted_position), .o_suffix_start(o_suffix_start),
        .o_lcp_with_previous(o_lcp_with_previous), .o_overflowed(o_overflowed),
        .o_last_result(o_last_result)
    );

    suffix_array_lcp_builder_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_char_byte(i_char_byte), .i_last_char(i_last_char), .i_valid(o_valid),
        .i_sorted_position(o_sorted_position), .i_suffix_start(o_suffix_start),
        .i_lcp_with_previous(o_lcp_with_previous), .i_overflowed(o_overflowed),
        .i_last_result(o_last_result), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog: counts cycles with no accepted transaction or result.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("[suffix_array_lcp_builder_top] ERROR");
            $finish;
        end
    end

    // Offer one byte, with a random idle gap first, and hold it until accepted.
    // Busy is stable from a falling edge to the next rising edge, so a byte
    // offered at a falling edge with busy low is taken at the next rising edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_char_byte <= b;
        i_last_char <= last;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // Send a whole text; the mode picks the byte pattern.
    task automatic send_text(input int len, input int mode);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: b = 8'($urandom);
                1: b = 8'h41 + 8'($urandom_range(1, 0));
                2: b = 8'h61;
                3: b = (i % 2) ? 8'hFF : 8'h00;
                default: b = 8'h30 + 8'(i % 3);
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    initial begin
        int len;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed texts: single byte, two bytes, extremes, repeats, overflow.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_text(2, 2);
        send_text(6, 3);
        send_text(9, 4);
        send_text(64, 2);
        send_text(70, 0);

        // Sender waits for every expected result before continuing.
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 67 : (phase == 2) ? 14 : 0;
            for (int t = 0; t < 2; t++) begin
                len = ($urandom_range(9, 0) == 0) ? $urandom_range(66, 60)
                                                  : $urandom_range(8, 1);
                send_text(len, $urandom_range(4, 0));
            end
        end

        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[suffix_array_lcp_builder_top] OK");
        end else begin
            $display("[suffix_array_lcp_builder_top] ERROR");
        end
        $finish;
    end

endmodule
